>>> hw/rtl/emp_pkg.sv
`default_nettype none

package emp_pkg;

  // default widths
  localparam int TIME_BITS_DEF   = 48;
  localparam int PERIOD_BITS_DEF = 32;

  // fixed field widths
  localparam int CMD_BITS     = 3;
  localparam int TIMEOUT_BITS = 32;
  localparam int COUNT_BITS   = 32;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 32'd2000000;

  // event commands
  typedef enum logic [CMD_BITS-1:0] {
    CMD_POWER_EDGE  = 3'd0,
    CMD_ALT_EDGE    = 3'd1,
    CMD_CHECK_POWER = 3'd2,
    CMD_CHECK_ALT   = 3'd3,
    CMD_SET_MODE    = 3'd4,
    CMD_CLEAR_COUNT = 3'd5
  } cmd_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TIMEOUT    = 1'd0,
    CFG_MODE_LEVEL = 1'd1
  } cfg_idx_t;

  // configuration values seen by the core
  typedef struct packed {
    logic [TIMEOUT_BITS-1:0] timeout_us;
    logic                    current_mode_level;
  } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/emp_if.sv
`default_nettype none

// event word channel
interface emp_in_if #(
  parameter int TIME_BITS = emp_pkg::TIME_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [emp_pkg::CMD_BITS-1:0]  command;
  logic [TIME_BITS-1:0]          now_us;
  logic                          want_voltage;

  modport source (output valid, command, now_us, want_voltage, input ready);
  modport sink   (input valid, command, now_us, want_voltage, output ready);
endinterface

// result word channel
interface emp_out_if #(
  parameter int PERIOD_BITS = emp_pkg::PERIOD_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [PERIOD_BITS-1:0]         power_period;
  logic [PERIOD_BITS-1:0]         current_period;
  logic [PERIOD_BITS-1:0]         voltage_period;
  logic [emp_pkg::COUNT_BITS-1:0] pulse_total;
  logic                           sel_level;
  logic                           measuring_voltage;

  modport source (output valid, power_period, current_period, voltage_period,
                  pulse_total, sel_level, measuring_voltage, input ready);
  modport sink   (input valid, power_period, current_period, voltage_period,
                  pulse_total, sel_level, measuring_voltage, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/emp_in_stage.sv
`default_nettype none

module emp_in_stage #(
  parameter int TIME_BITS = emp_pkg::TIME_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [emp_pkg::CMD_BITS-1:0] in_command,
  input  wire logic [TIME_BITS-1:0]         in_now_us,
  input  wire logic                         in_want_voltage,
  input  wire logic                         take,
  output logic                              held_valid,
  output logic [emp_pkg::CMD_BITS-1:0]      held_command,
  output logic [TIME_BITS-1:0]              held_now_us,
  output logic                              held_want_voltage
);

  logic                         valid_r;
  logic                         valid_nxt;
  logic [emp_pkg::CMD_BITS-1:0] command_r;
  logic [TIME_BITS-1:0]         now_r;
  logic                         want_r;
  logic                         load;

  // slot is free when empty or drained this cycle
  assign in_ready  = !valid_r || take;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      command_r <= in_command;
      now_r     <= in_now_us;
      want_r    <= in_want_voltage;
    end
  end

  assign held_valid        = valid_r;
  assign held_command      = command_r;
  assign held_now_us       = now_r;
  assign held_want_voltage = want_r;

endmodule

`default_nettype wire

>>> hw/rtl/emp_core.sv
`default_nettype none

module emp_core #(
  parameter int TIME_BITS   = emp_pkg::TIME_BITS_DEF,
  parameter int PERIOD_BITS = emp_pkg::PERIOD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire logic [emp_pkg::CMD_BITS-1:0] command,
  input  wire logic [TIME_BITS-1:0]         now_us,
  input  wire logic                         want_voltage,
  input  wire emp_pkg::cfg_t                cfg,
  output logic [PERIOD_BITS-1:0]            power_period,
  output logic [PERIOD_BITS-1:0]            current_period,
  output logic [PERIOD_BITS-1:0]            voltage_period,
  output logic [emp_pkg::COUNT_BITS-1:0]    pulse_total,
  output logic                              sel_level,
  output logic                              measuring_voltage
);

  localparam logic [TIME_BITS-1:0] PERIOD_MAX = TIME_BITS'({PERIOD_BITS{1'b1}});

  logic [TIME_BITS-1:0]           last_power_r, last_power_nxt;
  logic [TIME_BITS-1:0]           last_alt_r, last_alt_nxt;
  logic [TIME_BITS-1:0]           win_start_r, win_start_nxt;
  logic                           sel_r, sel_nxt;
  logic [PERIOD_BITS-1:0]         power_w_r, power_w_nxt;
  logic [PERIOD_BITS-1:0]         current_w_r, current_w_nxt;
  logic [PERIOD_BITS-1:0]         voltage_w_r, voltage_w_nxt;
  logic [emp_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic                           meas_r, meas_nxt;

  logic [TIME_BITS-1:0]   el_power;
  logic [TIME_BITS-1:0]   el_alt;
  logic [TIME_BITS-1:0]   el_win;
  logic [TIME_BITS-1:0]   tmo;
  logic [PERIOD_BITS-1:0] alt_period;
  logic                   is_current;

  function automatic logic [PERIOD_BITS-1:0] sat_period(input logic [TIME_BITS-1:0] d);
    logic [PERIOD_BITS-1:0] p;
    p = (d > PERIOD_MAX) ? {PERIOD_BITS{1'b1}} : d[PERIOD_BITS-1:0];
    return p;
  endfunction

  // elapsed times wrap at the timestamp width
  assign el_power   = now_us - last_power_r;
  assign el_alt     = now_us - last_alt_r;
  assign el_win     = now_us - win_start_r;
  assign tmo        = TIME_BITS'(cfg.timeout_us);
  assign is_current = (sel_r == cfg.current_mode_level);
  assign alt_period = (last_alt_r == win_start_r) ? '0 : sat_period(el_alt);

  // next state per command
  always_comb begin
    last_power_nxt = last_power_r;
    last_alt_nxt   = last_alt_r;
    win_start_nxt  = win_start_r;
    sel_nxt        = sel_r;
    power_w_nxt    = power_w_r;
    current_w_nxt  = current_w_r;
    voltage_w_nxt  = voltage_w_r;
    count_nxt      = count_r;
    case (emp_pkg::cmd_t'(command))
      emp_pkg::CMD_POWER_EDGE: begin
        power_w_nxt    = sat_period(el_power);
        last_power_nxt = now_us;
        count_nxt      = count_r + 1'b1;
      end
      emp_pkg::CMD_ALT_EDGE: begin
        if (el_win > tmo) begin
          if (is_current) begin
            current_w_nxt = alt_period;
          end else begin
            voltage_w_nxt = alt_period;
          end
          sel_nxt       = ~sel_r;
          win_start_nxt = now_us;
        end
        last_alt_nxt = now_us;
      end
      emp_pkg::CMD_CHECK_POWER: begin
        if (el_power > tmo) begin
          power_w_nxt = '0;
        end
      end
      emp_pkg::CMD_CHECK_ALT: begin
        if (el_alt > tmo) begin
          if (is_current) begin
            current_w_nxt = '0;
          end else begin
            voltage_w_nxt = '0;
          end
          sel_nxt       = ~sel_r;
          last_alt_nxt  = now_us;
          win_start_nxt = now_us;
        end
      end
      emp_pkg::CMD_SET_MODE: begin
        sel_nxt       = cfg.current_mode_level ^ want_voltage;
        last_alt_nxt  = now_us;
        win_start_nxt = now_us;
      end
      emp_pkg::CMD_CLEAR_COUNT: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    meas_nxt = (sel_nxt != cfg.current_mode_level);
  end

  // state doubles as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_power_r <= '0;
      last_alt_r   <= '0;
      win_start_r  <= '0;
      sel_r        <= 1'b0;
      power_w_r    <= '0;
      current_w_r  <= '0;
      voltage_w_r  <= '0;
      count_r      <= '0;
      meas_r       <= 1'b0;
    end else if (step) begin
      last_power_r <= last_power_nxt;
      last_alt_r   <= last_alt_nxt;
      win_start_r  <= win_start_nxt;
      sel_r        <= sel_nxt;
      power_w_r    <= power_w_nxt;
      current_w_r  <= current_w_nxt;
      voltage_w_r  <= voltage_w_nxt;
      count_r      <= count_nxt;
      meas_r       <= meas_nxt;
    end
  end

  assign power_period      = power_w_r;
  assign current_period    = current_w_r;
  assign voltage_period    = voltage_w_r;
  assign pulse_total       = count_r;
  assign sel_level         = sel_r;
  assign measuring_voltage = meas_r;

endmodule

`default_nettype wire

>>> hw/rtl/energy_meter_pulse_capture_core.sv
`default_nettype none

// channel   dir  handshake      payload
// in_ch     in   valid/ready    command, now_us, want_voltage
// out_ch    out  valid/ready    power/current/voltage_period, pulse_total,
//                               sel_level, measuring_voltage
// cfg_*     in   cfg_we only    cfg_index, cfg_wdata
//
// one word per cycle sustained while out_ch.ready stays high; a word's result reaches
// out_ch through the input register, then the state update into the result register
// the state registers are the result register, so the update of one word is
// finished before the next word is evaluated
// rst_n is synchronous: all pulse state, config and valid flags reset
// out_ch.ready low holds the result and lets one more word wait in the input
// register before in_ch.ready drops
module energy_meter_pulse_capture_core #(
  parameter int TIME_BITS   = emp_pkg::TIME_BITS_DEF,
  parameter int PERIOD_BITS = emp_pkg::PERIOD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  emp_in_if.sink                                 in_ch,
  emp_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [emp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [emp_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  emp_pkg::cfg_t                cfg_r;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic                         step;
  logic                         held_valid;
  logic [emp_pkg::CMD_BITS-1:0] held_command;
  logic [TIME_BITS-1:0]         held_now_us;
  logic                         held_want_voltage;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_us         <= emp_pkg::TIMEOUT_RESET;
      cfg_r.current_mode_level <= 1'b0;
    end else if (cfg_we) begin
      unique case (emp_pkg::cfg_idx_t'(cfg_index))
        emp_pkg::CFG_TIMEOUT:    cfg_r.timeout_us <= cfg_wdata[emp_pkg::TIMEOUT_BITS-1:0];
        emp_pkg::CFG_MODE_LEVEL: cfg_r.current_mode_level <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // input register
  emp_in_stage #(
    .TIME_BITS(TIME_BITS)
  ) u_in_stage (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_command        (in_ch.command),
    .in_now_us         (in_ch.now_us),
    .in_want_voltage   (in_ch.want_voltage),
    .take              (step),
    .held_valid        (held_valid),
    .held_command      (held_command),
    .held_now_us       (held_now_us),
    .held_want_voltage (held_want_voltage)
  );

  // advance when the result slot is free or drains now
  assign step          = held_valid && (!out_valid_r || out_ch.ready);
  assign out_valid_nxt = step ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // pulse state and result
  emp_core #(
    .TIME_BITS  (TIME_BITS),
    .PERIOD_BITS(PERIOD_BITS)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (step),
    .command           (held_command),
    .now_us            (held_now_us),
    .want_voltage      (held_want_voltage),
    .cfg               (cfg_r),
    .power_period      (out_ch.power_period),
    .current_period    (out_ch.current_period),
    .voltage_period    (out_ch.voltage_period),
    .pulse_total       (out_ch.pulse_total),
    .sel_level         (out_ch.sel_level),
    .measuring_voltage (out_ch.measuring_voltage)
  );

  assign out_ch.valid = out_valid_r;

endmodule

`default_nettype wire
